// ===== rtl/bfa_pkg.sv =====
// ============================================================================
// bfa_pkg : shared types and constants of the bitmap frame allocator
// Field widths, request and status codes, controller states and the
// configuration register bundle.
// ============================================================================
`default_nettype none

package bfa_pkg;

    // Default geometry of the used-bit store
    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_MAX_FRAMES = 32768;

    // Field widths
    localparam int FRAME_W = 20;
    localparam int CNT_W   = 16;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    // Configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(32768);

    // Register index (address bit 2)
    localparam logic REG_POOL_BASE   = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_MARK    = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_OUTSIDE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_DIV_MUL,
        S_DIV_ADJ,
        S_SCAN
    } t_state;

    // Configuration registers as seen by the engine
    typedef struct packed {
        logic [FRAME_W-1:0] pool_base;
        logic [CNT_W-1:0]   frame_count;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/bfa_ram.sv =====
// ============================================================================
// bfa_ram : generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module bfa_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bfa_regs.sv =====
// ============================================================================
// bfa_regs : configuration register file
// APB-style slave holding pool base and frame count; zero wait states.
// ============================================================================
`default_nettype none

module bfa_regs
    import bfa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic [APB_AW-1:0] i_paddr,
    input  wire logic [APB_DW-1:0] i_pwdata,
    output logic      [APB_DW-1:0] o_prdata,
    output t_cfg                   o_cfg
);

    logic [FRAME_W-1:0] r_pool_base;
    logic [CNT_W-1:0]   r_frame_count;
    logic               wr_en;
    logic               reg_idx;

    assign wr_en   = i_psel & i_penable & i_pwrite;
    assign reg_idx = i_paddr[2];

    // Register writes, taken in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= '0;
            r_frame_count <= FRAME_COUNT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_POOL_BASE:   r_pool_base   <= i_pwdata[FRAME_W-1:0];
                REG_FRAME_COUNT: r_frame_count <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_POOL_BASE:   o_prdata = APB_DW'(r_pool_base);
            REG_FRAME_COUNT: o_prdata = APB_DW'(r_frame_count);
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg.pool_base   = r_pool_base;
    assign o_cfg.frame_count = r_frame_count;

endmodule

`default_nettype wire

// ===== rtl/bfa_engine.sv =====
// ============================================================================
// bfa_engine : request sequencer of the frame allocator
// Clears the used-bit store after reset, then serves allocate, release and
// mark requests by read-modify-write of bitmap words, one word per cycle.
// ============================================================================
`default_nettype none

module bfa_engine
    import bfa_pkg::*;
#(
    parameter  int WORD_BITS  = DEF_WORD_BITS,
    parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
    localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS,
    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_start,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [FRAME_W-1:0]   i_frame_number,
    input  wire logic [CNT_W-1:0]     i_run_length,
    output logic                      o_busy,
    output logic                      o_done,
    output logic      [FRAME_W-1:0]   o_frame_number_res,
    output logic      [STAT_W-1:0]    o_status,
    // bitmap memory
    output logic                      o_mem_we,
    output logic      [AW-1:0]        o_mem_waddr,
    output logic      [WORD_BITS-1:0] o_mem_wdata,
    output logic                      o_mem_re,
    output logic      [AW-1:0]        o_mem_raddr,
    input  wire logic [WORD_BITS-1:0] i_mem_rdata
);

    // Pool index width, bit position width, reciprocal for index / WORD_BITS
    localparam int KW        = $clog2(MAX_FRAMES + 1);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int DIV_SHIFT = KW + BW;
    localparam int RW        = DIV_SHIFT;
    localparam int PW        = KW + RW;
    localparam longint RECIP = ((64'd1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [RW-1:0] RECIP_K   = RW'(RECIP);
    localparam logic [KW:0]   WB_K1     = (KW+1)'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [FRAME_W:0] SPAN   = (FRAME_W+1)'(1 << FRAME_W);

    // Control state
    t_state r_state, n_state;
    logic   r_done;
    logic   r_pend;
    logic [AW-1:0] r_clr_addr;

    // Request and working registers
    t_func              r_func;
    logic [FRAME_W-1:0] r_fnum;
    logic [CNT_W-1:0]   r_len;
    logic               r_set;
    logic [KW-1:0]      r_ks;
    logic [KW-1:0]      r_ke;
    t_status            r_status;
    logic [PW-1:0]      r_prod;
    logic [AW-1:0]      r_rd_word;
    logic [KW:0]        r_rd_kw;
    logic               r_rd_more;
    logic [AW-1:0]      r_pend_word;
    logic [KW:0]        r_pend_kw;
    logic [FRAME_W-1:0] r_res;
    t_status            r_out_status;

    // Pool size = min(frame_count, MAX_FRAMES, 2^20 - pool_base)
    logic [FRAME_W:0] base_w, span_w, fc_w, max_w, n_a, n_w, lim_w;
    logic [KW-1:0]    pool_n;

    assign base_w = {1'b0, i_cfg.pool_base};
    assign span_w = SPAN - base_w;
    assign fc_w   = (FRAME_W+1)'(i_cfg.frame_count);
    assign max_w  = (FRAME_W+1)'(MAX_FRAMES);
    assign n_a    = (fc_w < max_w) ? fc_w : max_w;
    assign n_w    = (n_a < span_w) ? n_a : span_w;
    assign pool_n = n_w[KW-1:0];
    assign lim_w  = base_w + n_w;

    // Clip the run [fnum, fnum+len) to the pool
    logic [FRAME_W:0] fnum_w, end_w, start_c, end_c, ks_w, ke_w;
    logic             outside;
    t_status          prep_st;

    assign fnum_w  = {1'b0, r_fnum};
    assign end_w   = fnum_w + (FRAME_W+1)'(r_len);
    assign start_c = (fnum_w > base_w) ? fnum_w : base_w;
    assign end_c   = (end_w < lim_w) ? end_w : lim_w;
    assign outside = (r_len != '0) && ((fnum_w < base_w) || (end_w > lim_w));
    assign prep_st = outside ? STAT_OUTSIDE : STAT_OK;
    assign ks_w    = start_c - base_w;
    assign ke_w    = end_c - base_w;

    // Word index of ks by reciprocal multiply
    logic [PW-1:0] prod_sh;
    logic [KW-1:0] q;
    logic [KW:0]   q_kw;

    assign prod_sh = r_prod >> DIV_SHIFT;
    assign q       = prod_sh[KW-1:0];
    assign q_kw    = {1'b0, q} * WB_K1;

    // Read pointer advance
    logic [KW:0] kw_next;
    logic        more_next;
    logic        last;

    assign kw_next   = r_rd_kw + WB_K1;
    assign more_next = kw_next < {1'b0, r_ke};
    assign last      = (r_pend_kw + WB_K1) >= {1'b0, r_ke};

    // Bits of the pending word that lie in [ks, ke)
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free;
    logic [WORD_BITS-1:0] low;
    logic [BW-1:0]        pos;
    logic                 found;

    always_comb begin
        logic [KW:0] idx;
        idx = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            idx     = r_pend_kw + (KW+1)'(j);
            mask[j] = (idx >= {1'b0, r_ks}) && (idx < {1'b0, r_ke});
        end
    end

    // Lowest free bit: isolate it, then encode
    assign free  = ~i_mem_rdata & mask;
    assign low   = free & (~free + WORD_BITS'(1));
    assign found = |free;

    always_comb begin
        pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (low[j]) begin
                pos = pos | BW'(j);
            end
        end
    end

    logic [FRAME_W:0] alloc_sum;
    assign alloc_sum = base_w + (FRAME_W+1)'(r_pend_kw) + (FRAME_W+1)'(pos);

    // Next state, memory control, result
    logic               fin;
    logic [FRAME_W-1:0] fin_res;
    t_status            fin_status;
    logic               issue;

    always_comb begin
        n_state     = r_state;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pend_word;
        o_mem_wdata = i_mem_rdata;
        fin         = 1'b0;
        fin_res     = '0;
        fin_status  = STAT_OK;
        case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                o_mem_wdata = '0;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_func == FN_ALLOC) begin
                    if (pool_n == '0) begin
                        fin        = 1'b1;
                        fin_status = STAT_FULL;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (start_c < end_c) begin
                    n_state = S_DIV_MUL;
                end else begin
                    fin        = 1'b1;
                    fin_status = prep_st;
                    n_state    = S_IDLE;
                end
            end
            S_DIV_MUL: n_state = S_DIV_ADJ;
            S_DIV_ADJ: n_state = S_SCAN;
            S_SCAN: begin
                if (r_pend) begin
                    if (r_func == FN_ALLOC) begin
                        if (found) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = i_mem_rdata | low;
                            fin         = 1'b1;
                            fin_res     = alloc_sum[FRAME_W-1:0];
                            n_state     = S_IDLE;
                        end else if (last) begin
                            fin        = 1'b1;
                            fin_status = STAT_FULL;
                            n_state    = S_IDLE;
                        end
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = r_set ? (i_mem_rdata | mask) : (i_mem_rdata & ~mask);
                        if (last) begin
                            fin        = 1'b1;
                            fin_status = r_status;
                            n_state    = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign issue       = (r_state == S_SCAN) && r_rd_more && !fin;
    assign o_mem_re    = issue;
    assign o_mem_raddr = r_rd_word;

    // State register and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_done     <= 1'b0;
            r_pend     <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= fin;
            r_pend  <= issue;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_res        <= fin_res;
            r_out_status <= fin_status;
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_func <= t_func'(i_func);
                    r_fnum <= i_frame_number;
                    r_set  <= (t_func'(i_func) == FN_MARK);
                    case (t_func'(i_func))
                        FN_RELEASE: r_len <= CNT_W'(1);
                        FN_MARK:    r_len <= i_run_length;
                        default:    r_len <= '0;
                    endcase
                end
            end
            S_PREP: begin
                if (r_func == FN_ALLOC) begin
                    r_ks      <= '0;
                    r_ke      <= pool_n;
                    r_rd_word <= '0;
                    r_rd_kw   <= '0;
                    r_rd_more <= 1'b1;
                end else begin
                    r_ks     <= ks_w[KW-1:0];
                    r_ke     <= ke_w[KW-1:0];
                    r_status <= prep_st;
                end
            end
            S_DIV_MUL: begin
                r_prod <= {{RW{1'b0}}, r_ks} * {{KW{1'b0}}, RECIP_K};
            end
            S_DIV_ADJ: begin
                r_rd_word <= q[AW-1:0];
                r_rd_kw   <= q_kw;
                r_rd_more <= 1'b1;
            end
            S_SCAN: begin
                if (issue) begin
                    r_pend_word <= r_rd_word;
                    r_pend_kw   <= r_rd_kw;
                    r_rd_word   <= r_rd_word + AW'(1);
                    r_rd_kw     <= kw_next;
                    r_rd_more   <= more_next;
                end
            end
            default: ;
        endcase
    end

    assign o_busy             = (r_state != S_IDLE);
    assign o_done             = r_done;
    assign o_frame_number_res = r_res;
    assign o_status           = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/bitmap_frame_allocator_unit.sv =====
// ============================================================================
// bitmap_frame_allocator_unit : page frame allocator with a used-bit bitmap
// Allocates the lowest free frame, releases a frame, or marks a run of
// frames used. The bitmap sits in one RAM of WORD_BITS-bit words.
// ============================================================================
//
//  channel   | signals                                   | transfer
//  ----------+-------------------------------------------+-------------------------
//  request   | i_func, i_frame_number, i_run_length      | start high, busy low
//  result    | o_frame_number_res, o_status              | o_done, one cycle only
//  config    | psel penable pwrite paddr pwdata prdata   | psel & penable & pwrite
//
//  Allocate scans the bitmap from word 0, one bitmap word per cycle; release and
//  mark find their first word by reciprocal multiply, then rewrite each word of
//  the run; a request with no word ends in S_PREP. The result strobe is registered
//  and rises as busy falls. Reset: synchronous; a clearing pass zeroes all
//  NUM_WORDS bitmap words (1024 at the defaults) while busy stays high.
//  The result side has no back-pressure; busy covers the whole request.
// ============================================================================
`default_nettype none

module bitmap_frame_allocator_unit
    import bfa_pkg::*;
#(
    parameter  int WORD_BITS  = DEF_WORD_BITS,
    parameter  int MAX_FRAMES = DEF_MAX_FRAMES,
    localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS,
    localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic      [APB_DW-1:0]  prdata,
    output logic                    pready,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [FRAME_W-1:0] i_frame_number,
    input  wire logic [CNT_W-1:0]   i_run_length,
    // result
    output logic                    o_done,
    output logic      [FRAME_W-1:0] o_frame_number_res,
    output logic      [STAT_W-1:0]  o_status
);

    t_cfg                 cfg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    assign pready = 1'b1;

    // Configuration registers
    bfa_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // Request sequencer
    bfa_engine #(
        .WORD_BITS  (WORD_BITS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_start            (start),
        .i_func             (i_func),
        .i_frame_number     (i_frame_number),
        .i_run_length       (i_run_length),
        .o_busy             (busy),
        .o_done             (o_done),
        .o_frame_number_res (o_frame_number_res),
        .o_status           (o_status),
        .o_mem_we           (mem_we),
        .o_mem_waddr        (mem_waddr),
        .o_mem_wdata        (mem_wdata),
        .o_mem_re           (mem_re),
        .o_mem_raddr        (mem_raddr),
        .i_mem_rdata        (mem_rdata)
    );

    // Used-bit bitmap
    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/bfa_checker.sv =====
// ============================================================================
// bfa_checker : port-level checks of the frame allocator
// Watches request and result ports over time; bound to the top level.
// ============================================================================
`default_nettype none

module bfa_checker
    import bfa_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_done,
    input wire logic [FRAME_W-1:0] o_frame_number_res,
    input wire logic [STAT_W-1:0]  o_status
);

    // Leaving reset starts the bitmap clearing pass
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("busy low when reset is released");

    // An accepted request keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer not followed by busy");

    // A result only ends a busy period and never comes twice in a row
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) && !busy))
        else $error("result strobe without a request in progress");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // Failed results carry frame 0
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STAT_OK)) |-> (o_frame_number_res == '0))
        else $error("non-zero frame number with error status");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_frame_number_res (o_frame_number_res),
    .o_status           (o_status)
);

`default_nettype wire
